// ===== hdl/dsecd_pkg.sv =====
`default_nettype none

package dsecd_pkg;

   localparam int BYTE_W     = 8;
   localparam int CRC_W      = 16;
   localparam int STATUS_W   = 3;
   localparam int INDEX_W    = 6;
   localparam int COUNT_W    = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

   localparam logic [CRC_W-1:0]  CRC_INIT_RESET = 16'hFFFF;
   localparam logic [BYTE_W-1:0] ESCAPE_RESET   = 8'h10;
   localparam logic [BYTE_W-1:0] START_RESET    = 8'h02;
   localparam logic [BYTE_W-1:0] END_RESET      = 8'h03;

   localparam logic [CSR_ADDR_W-1:0] CSR_CRC_INIT = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ESCAPE   = 4'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_START    = 4'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_END      = 4'd3;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type STAT_PAYLOAD  = 3'd0;
   localparam status_type STAT_EMPTY    = 3'd1;
   localparam status_type STAT_CRC_ERR  = 3'd2;
   localparam status_type STAT_OVERFLOW = 3'd3;
   localparam status_type STAT_BAD_ESC  = 3'd4;

   typedef struct packed {
      logic       store;
      logic       clear_fill;
      logic       start_crc;
      logic       crc_read;
      logic       emit_start;
      logic       emit_read;
      logic       load_payload;
      logic       event_load;
      status_type event_code;
   } dsecd_cmd_type;

   typedef struct packed {
      logic out_free;
      logic byte_is_escape;
      logic byte_is_start;
      logic byte_is_end;
      logic fill_at_limit;
      logic fill_ge2;
      logic idx_eq_len;
      logic idx_last;
      logic crc_pending;
      logic crc_match;
      logic len_zero;
   } dsecd_sts_type;

   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {data, 8'h00};
      for (int b = 0; b < 8; b++) begin
         c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/dsecd_req_if.sv =====
`default_nettype none

interface dsecd_req_if import dsecd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/dsecd_rsp_if.sv =====
`default_nettype none

interface dsecd_rsp_if import dsecd_pkg::*; ();
   logic               valid;
   logic               ready;
   status_type         status;
   logic [BYTE_W-1:0]  payload_byte;
   logic [INDEX_W-1:0] byte_index;
   logic [INDEX_W-1:0] frame_length;
   logic               last;
   logic [COUNT_W-1:0] good_count;
   logic [COUNT_W-1:0] crc_error_count;
   logic [COUNT_W-1:0] overflow_count;
   logic [COUNT_W-1:0] escape_error_count;

   modport source (output valid, output status, output payload_byte, output byte_index,
                   output frame_length, output last, output good_count,
                   output crc_error_count, output overflow_count,
                   output escape_error_count, input ready);
   modport sink (input valid, input status, input payload_byte, input byte_index,
                 input frame_length, input last, input good_count,
                 input crc_error_count, input overflow_count,
                 input escape_error_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/dsecd_csr_if.sv =====
`default_nettype none

interface dsecd_csr_if import dsecd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

// ===== hdl/dsecd_ram.sv =====
`default_nettype none

module dsecd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/dsecd_ctl.sv =====
`default_nettype none

module dsecd_ctl import dsecd_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire dsecd_sts_type  sts,
   output dsecd_cmd_type       cmd
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_CRC     = 2'd1;
   localparam logic [1:0] ST_EMIT_RD = 2'd2;
   localparam logic [1:0] ST_EMIT_LD = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       in_frame_ff, in_frame_in;
   logic       esc_ff, esc_in;
   logic       accept;
   logic       do_store;

   assign req_ready = (state_ff == ST_IDLE) && sts.out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in    = state_ff;
      in_frame_in = in_frame_ff;
      esc_in      = esc_ff;
      do_store    = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!in_frame_ff) begin
                  if (esc_ff) begin
                     esc_in = 1'b0;
                     if (sts.byte_is_start) begin
                        in_frame_in    = 1'b1;
                        cmd.clear_fill = 1'b1;
                     end
                  end else if (sts.byte_is_escape) begin
                     esc_in = 1'b1;
                  end
               end else if (esc_ff) begin
                  esc_in = 1'b0;
                  if (sts.byte_is_escape) begin
                     do_store = 1'b1;
                  end else if (sts.byte_is_end) begin
                     in_frame_in    = 1'b0;
                     cmd.clear_fill = 1'b1;
                     if (!sts.fill_ge2) begin
                        cmd.event_load = 1'b1;
                        cmd.event_code = STAT_CRC_ERR;
                     end else begin
                        cmd.start_crc = 1'b1;
                        state_in      = ST_CRC;
                     end
                  end else begin
                     in_frame_in    = 1'b0;
                     cmd.clear_fill = 1'b1;
                     cmd.event_load = 1'b1;
                     cmd.event_code = STAT_BAD_ESC;
                  end
               end else if (sts.byte_is_escape) begin
                  esc_in = 1'b1;
               end else begin
                  do_store = 1'b1;
               end
            end
         end
         ST_CRC: begin
            if (!sts.idx_eq_len) begin
               cmd.crc_read = 1'b1;
            end else if (!sts.crc_pending && sts.out_free) begin
               if (!sts.crc_match) begin
                  cmd.event_load = 1'b1;
                  cmd.event_code = STAT_CRC_ERR;
                  state_in       = ST_IDLE;
               end else if (sts.len_zero) begin
                  cmd.event_load = 1'b1;
                  cmd.event_code = STAT_EMPTY;
                  state_in       = ST_IDLE;
               end else begin
                  cmd.emit_start = 1'b1;
                  state_in       = ST_EMIT_RD;
               end
            end
         end
         ST_EMIT_RD: begin
            if (sts.out_free) begin
               cmd.emit_read = 1'b1;
               state_in      = ST_EMIT_LD;
            end
         end
         ST_EMIT_LD: begin
            cmd.load_payload = 1'b1;
            state_in         = sts.idx_last ? ST_IDLE : ST_EMIT_RD;
         end
      endcase
      if (do_store) begin
         if (sts.fill_at_limit) begin
            in_frame_in    = 1'b0;
            esc_in         = 1'b0;
            cmd.clear_fill = 1'b1;
            cmd.event_load = 1'b1;
            cmd.event_code = STAT_OVERFLOW;
         end else begin
            cmd.store = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         in_frame_ff <= 1'b0;
         esc_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         in_frame_ff <= in_frame_in;
         esc_ff      <= esc_in;
      end
   end

`ifndef SYNTHESIS
   a_check_outside_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (!in_frame_ff && !esc_ff))
      else $error("Frame state is live while a closed frame is processed.");

   a_load_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_LD) |-> ($past(state_ff) == ST_EMIT_RD))
      else $error("Payload load was not preceded by a buffer read.");
`endif

endmodule

`default_nettype wire

// ===== hdl/dsecd_dp.sv =====
`default_nettype none

module dsecd_dp import dsecd_pkg::*; #(
   parameter int FRAME_DEPTH = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [BYTE_W-1:0] rx_byte,
   input  wire dsecd_cmd_type     cmd,
   output dsecd_sts_type          sts,
   dsecd_rsp_if.source            rsp_chan,
   dsecd_csr_if.sink              csr_chan
);

   localparam int ADDR_W = $clog2(FRAME_DEPTH);
   localparam logic [ADDR_W-1:0] FILL_LIMIT = ADDR_W'(FRAME_DEPTH - 1);

   logic [CRC_W-1:0]   crc_init_ff, crc_init_in;
   logic [BYTE_W-1:0]  escape_ff, escape_in;
   logic [BYTE_W-1:0]  start_ff, start_in;
   logic [BYTE_W-1:0]  etx_ff, etx_in;
   logic [ADDR_W-1:0]  fill_ff, fill_in;
   logic [BYTE_W-1:0]  prev_ff, prev_in;
   logic [BYTE_W-1:0]  last_byte_ff, last_byte_in;
   logic [ADDR_W-1:0]  len_ff, len_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [CRC_W-1:0]   crc_ff, crc_in;
   logic               pend_ff, pend_in;
   logic               out_valid_ff, out_valid_in;
   status_type         out_status_ff, out_status_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic [INDEX_W-1:0] out_index_ff, out_index_in;
   logic [INDEX_W-1:0] out_length_ff, out_length_in;
   logic               out_last_ff, out_last_in;
   logic [COUNT_W-1:0] good_ff, good_in;
   logic [COUNT_W-1:0] crc_err_ff, crc_err_in;
   logic [COUNT_W-1:0] ovf_ff, ovf_in;
   logic [COUNT_W-1:0] esc_err_ff, esc_err_in;
   logic [BYTE_W-1:0]  ram_rdata;
   logic               out_free;

   dsecd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FRAME_DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (fill_ff),
      .wr_data (rx_byte),
      .rd_en   (cmd.crc_read || cmd.emit_read),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   assign out_free = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      sts.out_free       = out_free;
      sts.byte_is_escape = (rx_byte == escape_ff);
      sts.byte_is_start  = (rx_byte == start_ff);
      sts.byte_is_end    = (rx_byte == etx_ff);
      sts.fill_at_limit  = (fill_ff == FILL_LIMIT);
      sts.fill_ge2       = (fill_ff >= ADDR_W'(2));
      sts.idx_eq_len     = (idx_ff == len_ff);
      sts.idx_last       = (idx_ff == (len_ff - ADDR_W'(1)));
      sts.crc_pending    = pend_ff;
      sts.crc_match      = (crc_ff == {last_byte_ff, prev_ff});
      sts.len_zero       = (len_ff == '0);
   end

   always_comb begin
      crc_init_in = crc_init_ff;
      escape_in   = escape_ff;
      start_in    = start_ff;
      etx_in      = etx_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.addr)
            CSR_CRC_INIT: crc_init_in = csr_chan.wdata;
            CSR_ESCAPE:   escape_in   = csr_chan.wdata[BYTE_W-1:0];
            CSR_START:    start_in    = csr_chan.wdata[BYTE_W-1:0];
            CSR_END:      etx_in      = csr_chan.wdata[BYTE_W-1:0];
            default: ;
         endcase
      end

      fill_in      = fill_ff;
      prev_in      = prev_ff;
      last_byte_in = last_byte_ff;
      if (cmd.clear_fill) begin
         fill_in = '0;
      end else if (cmd.store) begin
         fill_in = fill_ff + ADDR_W'(1);
      end
      if (cmd.store) begin
         prev_in      = last_byte_ff;
         last_byte_in = rx_byte;
      end

      len_in = cmd.start_crc ? (fill_ff - ADDR_W'(2)) : len_ff;

      idx_in = idx_ff;
      if (cmd.start_crc || cmd.emit_start) begin
         idx_in = '0;
      end else if (cmd.crc_read || cmd.load_payload) begin
         idx_in = idx_ff + ADDR_W'(1);
      end

      pend_in = cmd.crc_read;
      crc_in  = crc_ff;
      if (cmd.start_crc) begin
         crc_in = crc_init_ff;
      end else if (pend_ff) begin
         crc_in = crc_byte(crc_ff, ram_rdata);
      end

      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_byte_in   = out_byte_ff;
      out_index_in  = out_index_ff;
      out_length_in = out_length_ff;
      out_last_in   = out_last_ff;
      if (cmd.event_load) begin
         out_valid_in  = 1'b1;
         out_status_in = cmd.event_code;
         out_byte_in   = '0;
         out_index_in  = '0;
         out_length_in = '0;
         out_last_in   = 1'b1;
      end else if (cmd.load_payload) begin
         out_valid_in  = 1'b1;
         out_status_in = STAT_PAYLOAD;
         out_byte_in   = ram_rdata;
         out_index_in  = INDEX_W'(idx_ff);
         out_length_in = INDEX_W'(len_ff);
         out_last_in   = sts.idx_last;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      good_in    = good_ff;
      crc_err_in = crc_err_ff;
      ovf_in     = ovf_ff;
      esc_err_in = esc_err_ff;
      if (cmd.emit_start) begin
         good_in = good_ff + COUNT_W'(1);
      end
      if (cmd.event_load) begin
         unique case (cmd.event_code)
            STAT_EMPTY:    good_in    = good_ff + COUNT_W'(1);
            STAT_CRC_ERR:  crc_err_in = crc_err_ff + COUNT_W'(1);
            STAT_OVERFLOW: ovf_in     = ovf_ff + COUNT_W'(1);
            STAT_BAD_ESC:  esc_err_in = esc_err_ff + COUNT_W'(1);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_init_ff  <= CRC_INIT_RESET;
         escape_ff    <= ESCAPE_RESET;
         start_ff     <= START_RESET;
         etx_ff       <= END_RESET;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         good_ff      <= '0;
         crc_err_ff   <= '0;
         ovf_ff       <= '0;
         esc_err_ff   <= '0;
      end else begin
         crc_init_ff  <= crc_init_in;
         escape_ff    <= escape_in;
         start_ff     <= start_in;
         etx_ff       <= etx_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
         good_ff      <= good_in;
         crc_err_ff   <= crc_err_in;
         ovf_ff       <= ovf_in;
         esc_err_ff   <= esc_err_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff       <= prev_in;
      last_byte_ff  <= last_byte_in;
      len_ff        <= len_in;
      idx_ff        <= idx_in;
      crc_ff        <= crc_in;
      out_status_ff <= out_status_in;
      out_byte_ff   <= out_byte_in;
      out_index_ff  <= out_index_in;
      out_length_ff <= out_length_in;
      out_last_ff   <= out_last_in;
   end

   assign csr_chan.ready              = 1'b1;
   assign rsp_chan.valid              = out_valid_ff;
   assign rsp_chan.status             = out_status_ff;
   assign rsp_chan.payload_byte       = out_byte_ff;
   assign rsp_chan.byte_index         = out_index_ff;
   assign rsp_chan.frame_length       = out_length_ff;
   assign rsp_chan.last               = out_last_ff;
   assign rsp_chan.good_count         = good_ff;
   assign rsp_chan.crc_error_count    = crc_err_ff;
   assign rsp_chan.overflow_count     = ovf_ff;
   assign rsp_chan.escape_error_count = esc_err_ff;

`ifndef SYNTHESIS
   a_store_below_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> (fill_ff != FILL_LIMIT))
      else $error("Byte stored into a full frame buffer.");

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.event_load || cmd.load_payload) |-> out_free)
      else $error("Result register overwritten before its transaction.");

   a_crc_read_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.crc_read |-> (idx_ff != len_ff))
      else $error("CRC pass read beyond the frame payload.");
`endif

endmodule

`default_nettype wire

// ===== hdl/dle_stx_etx_crc_deframer_unit.sv =====
// Deframer for a DLE/STX/ETX byte-stuffed link with a CRC-16-CCITT trailer.
// The req_chan channel takes one received byte per transaction; csr_chan writes
// the CRC initial value and the escape, start and end codes (index 0 to 3).
// Each frame is stored unstuffed in an internal buffer of FRAME_DEPTH bytes.
// The rsp_chan channel returns one transaction per payload byte of a good
// frame, a single empty-frame result, or one error event (CRC error, overflow,
// bad escape); every result carries the four running frame counters.
// Bytes that end no frame stream at one per cycle while the output register is
// free. At a frame end the block reads the buffer once to compute the CRC, then
// reads it again to emit the payload, one byte per read through the single
// buffer read port and its registered read data. No new byte is taken during
// these passes. Results are held in an output register; a stalled receiver
// holds the result and blocks further input until it is taken.
// Reset restores the register defaults, clears the counters and returns the
// block to hunting for a start sequence; the buffer itself is not cleared.
`default_nettype none

module dle_stx_etx_crc_deframer_unit import dsecd_pkg::*; #(
   parameter int FRAME_DEPTH = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   dsecd_req_if.sink    req_chan,
   dsecd_rsp_if.source  rsp_chan,
   dsecd_csr_if.sink    csr_chan
);

   dsecd_cmd_type cmd;
   dsecd_sts_type sts;
   logic          req_ready;

   assign req_chan.ready = req_ready;

   dsecd_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dsecd_dp #(
      .FRAME_DEPTH (FRAME_DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .rx_byte  (req_chan.rx_byte),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

endmodule

`default_nettype wire
